/* src/rinse_aid_dose_sequencer_macros.svh */
// Assertion macros shared by the sequencer RTL.
`ifndef RINSE_AID_DOSE_SEQUENCER_MACROS_SVH
`define RINSE_AID_DOSE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RADS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rads: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define RADS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rads: next-cycle check failed");

`endif

/* src/rads_pkg.sv */
package rads_pkg;

   // Sequence phases; codes above PH_ERROR are unused and fall back to init
   typedef enum logic [3:0] {
      PH_INIT    = 4'd0,
      PH_T1      = 4'd1,
      PH_WAIT_D1 = 4'd2,
      PH_D1      = 4'd3,
      PH_WAIT_D2 = 4'd4,
      PH_D2      = 4'd5,
      PH_WAIT_T2 = 4'd6,
      PH_T2      = 4'd7,
      PH_END     = 4'd8,
      PH_ERROR   = 4'd9
   } phase_type;

   // Dosing options
   localparam logic [2:0] OPT_PLAIN     = 3'd0;
   localparam logic [2:0] OPT_TURB      = 3'd1;
   localparam logic [2:0] OPT_REG       = 3'd2;
   localparam logic [2:0] OPT_REG_TURB  = 3'd3;

   // Control register indexes
   localparam int unsigned CsrIdxW = 3;
   localparam logic [CsrIdxW-1:0] CSR_DOSE_TIME       = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_SECOND_DOSE     = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_READ_TO_DOSE    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_DOSE_GAP        = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_DOSE_TO_READ    = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_TURB_DELTA      = 3'd5;

   localparam int unsigned CsrDataW = 16;
   localparam logic [15:0] TimeReset  = 16'd10;
   localparam logic [6:0]  DeltaReset = 7'd5;
   localparam logic [7:0]  FullScale  = 8'd100;
   localparam logic [3:0]  DoseCountMax = 4'd15;

   localparam int unsigned ReqDataW = 32;
   localparam int unsigned RspDataW = 8;

   typedef struct packed {
      logic [15:0] dose_time;
      logic [15:0] second_dose_time;
      logic [15:0] read_to_dose_delay;
      logic [15:0] dose_gap_delay;
      logic [15:0] dose_to_read_delay;
      logic [6:0]  turbidity_delta;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] countdown;
      logic        counting;
      logic [7:0]  seen_read_id;
      logic        read_pending;
      logic [3:0]  dose_count;
      logic [6:0]  first_turbidity;
   } state_type;

   typedef struct packed {
      logic       restart;
      logic       door_wait;
      logic [2:0] option;
      logic       load_ok;
      logic       table_long;
      logic [3:0] dose_level;
      logic       sensor_valid;
      logic [7:0] read_id;
      logic [6:0] turbidity;
      logic       level_switch_set;
   } item_type;

   typedef struct packed {
      logic done_res;
      logic dispenser_on;
      logic read_enable;
      logic read_disable;
      logic verdict_valid;
      logic aid_missing;
   } result_type;

endpackage

/* src/rads_csr.sv */
module rads_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rads_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [rads_pkg::CsrDataW-1:0]       csr_wr_data,
   output rads_pkg::cfg_type                   cfg
);

   rads_pkg::cfg_type cfg_ff, cfg_in;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rads_pkg::CSR_DOSE_TIME:    cfg_in.dose_time          = csr_wr_data;
            rads_pkg::CSR_SECOND_DOSE:  cfg_in.second_dose_time   = csr_wr_data;
            rads_pkg::CSR_READ_TO_DOSE: cfg_in.read_to_dose_delay = csr_wr_data;
            rads_pkg::CSR_DOSE_GAP:     cfg_in.dose_gap_delay     = csr_wr_data;
            rads_pkg::CSR_DOSE_TO_READ: cfg_in.dose_to_read_delay = csr_wr_data;
            rads_pkg::CSR_TURB_DELTA:   cfg_in.turbidity_delta    = csr_wr_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dose_time          <= rads_pkg::TimeReset;
         cfg_ff.second_dose_time   <= rads_pkg::TimeReset;
         cfg_ff.read_to_dose_delay <= rads_pkg::TimeReset;
         cfg_ff.dose_gap_delay     <= rads_pkg::TimeReset;
         cfg_ff.dose_to_read_delay <= rads_pkg::TimeReset;
         cfg_ff.turbidity_delta    <= rads_pkg::DeltaReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/rads_step.sv */
module rads_step (
   input  rads_pkg::cfg_type    cfg,
   input  rads_pkg::state_type  cur,
   input  rads_pkg::item_type   item,
   output rads_pkg::state_type  nxt,
   output rads_pkg::result_type res
);

   logic              run;
   logic [3:0]        dose_cnt_inc;
   logic signed [8:0] rise;
   logic [7:0]        first_plus_delta;
   logic              new_read;

   // Turbidity rise and headroom, evaluated against the stored first read
   assign rise = $signed({2'b00, item.turbidity}) - $signed({2'b00, cur.first_turbidity});
   assign first_plus_delta = {1'b0, cur.first_turbidity} + {1'b0, cfg.turbidity_delta};
   assign dose_cnt_inc = (cur.dose_count < rads_pkg::DoseCountMax) ?
                         cur.dose_count + 4'd1 : cur.dose_count;

   // A pending read re-arm captures the id first, so compare against the updated id
   assign new_read = item.sensor_valid &&
                     ((cur.read_pending ? item.read_id : cur.seen_read_id) != item.read_id);

   always_comb begin
      nxt = cur;
      res = '0;
      run = 1'b1;
      if (item.restart) begin
         nxt.phase = rads_pkg::PH_INIT;
      end else if (item.door_wait) begin
         nxt.counting = 1'b0;
         if (cur.phase == rads_pkg::PH_T1 || cur.phase == rads_pkg::PH_T2) begin
            nxt.read_pending = 1'b1;
         end
      end else begin
         // timer tick
         if (cur.counting && cur.countdown != 16'd0) begin
            nxt.countdown = cur.countdown - 16'd1;
         end
         if (cur.read_pending) begin
            nxt.seen_read_id = item.read_id;
            nxt.read_pending = 1'b0;
            res.read_enable  = 1'b1;
         end
         unique case (cur.phase)
            rads_pkg::PH_INIT: begin
               if (!item.load_ok) begin
                  nxt.phase = rads_pkg::PH_ERROR;
                  run = 1'b0;
               end else if (item.dose_level == 4'd0) begin
                  res.done_res = 1'b1;
                  run = 1'b0;
               end else begin
                  nxt.countdown = 16'd0;
                  priority if (item.option == rads_pkg::OPT_PLAIN) begin
                     nxt.phase = rads_pkg::PH_WAIT_D1;
                  end else if (item.option == rads_pkg::OPT_TURB ||
                               item.option == rads_pkg::OPT_REG_TURB) begin
                     if (!item.table_long) begin
                        nxt.phase = rads_pkg::PH_ERROR;
                        run = 1'b0;
                     end else begin
                        nxt.phase = rads_pkg::PH_T1;
                        nxt.read_pending = 1'b1;
                        nxt.dose_count = 4'd0;
                     end
                  end else if (item.option == rads_pkg::OPT_REG) begin
                     nxt.phase = rads_pkg::PH_WAIT_D1;
                     nxt.dose_count = 4'd0;
                  end else begin
                     nxt.phase = rads_pkg::PH_ERROR;
                  end
               end
            end
            rads_pkg::PH_T1: begin
               if (new_read) begin
                  nxt.seen_read_id    = item.read_id;
                  nxt.first_turbidity = item.turbidity;
                  nxt.phase           = rads_pkg::PH_WAIT_D1;
                  nxt.countdown       = cfg.read_to_dose_delay;
                  res.read_disable    = 1'b1;
               end
            end
            rads_pkg::PH_WAIT_D1: begin
               if (nxt.countdown == 16'd0) begin
                  nxt.phase     = rads_pkg::PH_D1;
                  nxt.countdown = cfg.dose_time;
               end
            end
            rads_pkg::PH_D1: begin
               if (nxt.countdown == 16'd0) begin
                  nxt.phase     = rads_pkg::PH_WAIT_D2;
                  nxt.countdown = cfg.dose_gap_delay;
               end else begin
                  res.dispenser_on = 1'b1;
               end
            end
            rads_pkg::PH_WAIT_D2: begin
               if (nxt.countdown == 16'd0) begin
                  if (item.option == rads_pkg::OPT_REG ||
                      item.option == rads_pkg::OPT_REG_TURB) begin
                     nxt.dose_count = dose_cnt_inc;
                     if (dose_cnt_inc >= item.dose_level) begin
                        nxt.phase = (item.option == rads_pkg::OPT_REG_TURB) ?
                                    rads_pkg::PH_WAIT_T2 : rads_pkg::PH_END;
                     end else begin
                        nxt.phase     = rads_pkg::PH_D1;
                        nxt.countdown = cfg.dose_time;
                     end
                  end else begin
                     nxt.phase     = rads_pkg::PH_D2;
                     nxt.countdown = cfg.second_dose_time;
                  end
               end
            end
            rads_pkg::PH_D2: begin
               if (nxt.countdown == 16'd0) begin
                  priority if (item.option == rads_pkg::OPT_PLAIN) begin
                     nxt.phase = rads_pkg::PH_END;
                  end else if (item.option == rads_pkg::OPT_TURB) begin
                     nxt.phase = rads_pkg::PH_WAIT_T2;
                  end else begin
                     nxt.phase = rads_pkg::PH_ERROR;
                  end
                  nxt.countdown = cfg.dose_to_read_delay;
               end else begin
                  res.dispenser_on = 1'b1;
               end
            end
            rads_pkg::PH_WAIT_T2: begin
               if (nxt.countdown == 16'd0) begin
                  nxt.phase        = rads_pkg::PH_T2;
                  nxt.read_pending = 1'b1;
               end
            end
            rads_pkg::PH_T2: begin
               if (new_read) begin
                  res.verdict_valid = 1'b1;
                  res.aid_missing   = !item.level_switch_set &&
                                      (rise <= $signed({2'b00, cfg.turbidity_delta})) &&
                                      (first_plus_delta < rads_pkg::FullScale);
                  nxt.phase        = rads_pkg::PH_END;
                  res.read_disable = 1'b1;
               end
            end
            rads_pkg::PH_END,
            rads_pkg::PH_ERROR: begin
               res.done_res = 1'b1;
            end
            default: begin
               nxt.phase = rads_pkg::PH_INIT;
            end
         endcase
         if (run) begin
            nxt.counting = 1'b1;
         end
      end
   end

endmodule

/* src/rinse_aid_dose_sequencer.sv */
// Rinse-aid dose sequencer.
// req_* carries one tick word per control step (tdata fields listed at the port).
// rsp_* returns exactly one result word per accepted tick, in order.
// csr_* writes the phase times and the turbidity delta; write only while idle.
// Each accepted tick is evaluated in the same cycle against the sequence state
// and the result lands in an output register, so rsp_tvalid rises in the cycle
// after the accept. Throughput is one word per cycle while the receiver keeps up;
// the state update and the result both come from one combinational step between
// the state registers and the output register.
// req_tready is high while the output register is empty or is being drained, so
// a stalled receiver holds one result and stops further ticks until it is taken.
// Reset (synchronous) returns the phase to init, clears the timer, read tracking
// and dose counter, empties the output register and restores register defaults
// (all times 10, delta 5).
`include "rinse_aid_dose_sequencer_macros.svh"

module rinse_aid_dose_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   // restart, door_wait, option[2:0], load_ok, table_long, dose_level[3:0],
   // sensor_valid, read_id[7:0], turbidity[6:0], level_switch_set, zero pad
   input  logic [rads_pkg::ReqDataW-1:0]       req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // done_res, dispenser_on, read_enable, read_disable, verdict_valid,
   // aid_missing, zero pad
   output logic [rads_pkg::RspDataW-1:0]       rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wr_en,
   input  logic [rads_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [rads_pkg::CsrDataW-1:0]       csr_wr_data
);

   rads_pkg::cfg_type    cfg;
   rads_pkg::item_type   item;
   rads_pkg::state_type  state_ff, state_in;
   rads_pkg::result_type res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [rads_pkg::RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic                 req_acc;

   rads_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // Unpack the tick word
   assign item.restart          = req_tdata[0];
   assign item.door_wait        = req_tdata[1];
   assign item.option           = req_tdata[4:2];
   assign item.load_ok          = req_tdata[5];
   assign item.table_long       = req_tdata[6];
   assign item.dose_level       = req_tdata[10:7];
   assign item.sensor_valid     = req_tdata[11];
   assign item.read_id          = req_tdata[19:12];
   assign item.turbidity        = req_tdata[26:20];
   assign item.level_switch_set = req_tdata[27];

   rads_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (item),
      .nxt  (state_in),
      .res  (res_in)
   );

   // Handshake: take a word whenever the output slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_acc) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, res_in.aid_missing, res_in.verdict_valid,
                         res_in.read_disable, res_in.read_enable,
                         res_in.dispenser_on, res_in.done_res};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= rads_pkg::PH_INIT;
         state_ff.countdown       <= '0;
         state_ff.counting        <= 1'b0;
         state_ff.seen_read_id    <= '0;
         state_ff.read_pending    <= 1'b0;
         state_ff.dose_count      <= '0;
         state_ff.first_turbidity <= '0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         if (req_acc) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // Checks
   `RADS_ASSERT_NOW(a_no_take_when_full, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready)
   `RADS_ASSERT_NEXT(a_restart_to_init, clock, reset, req_acc && item.restart, state_ff.phase == rads_pkg::PH_INIT)
   `RADS_ASSERT_NEXT(a_door_stops_timer, clock, reset, req_acc && !item.restart && item.door_wait, !state_ff.counting)
   `RADS_ASSERT_NOW(a_dispense_in_dose, clock, reset, req_acc && res_in.dispenser_on, state_ff.phase == rads_pkg::PH_D1 || state_ff.phase == rads_pkg::PH_D2)

endmodule

/* tb/tb.sv */
module tb;
   import rads_pkg::*;

   // Option codes past the defined ones all land in the error phase
   localparam logic [2:0] OPT_FIRST_BAD = 3'd4;
   localparam logic [2:0] OPT_LAST_BAD  = 3'd7;
   localparam int         PRINT_CAP     = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wr_data = '0;

   rinse_aid_dose_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Shadow copy of the sequencer state and its registers
   cfg_type     dosing_cfg;
   phase_type   ph;
   logic [15:0] countdown;
   logic        counting;
   logic [7:0]  seen_id;
   logic        read_pending;
   logic [3:0]  dose_count;
   logic [6:0]  first_turb;

   result_type  due_outputs[$];

   int error_count   = 0;
   int ticks_checked = 0;
   int verdict_count = 0;
   int missing_count = 0;
   int done_count    = 0;
   int dispense_count = 0;

   // Traffic shaping knobs, set per test
   int       tx_max_gap = 0;
   int       burst_left = 0;
   int       rx_mode = 0;
   int       rx_run = 0;
   logic     rx_hold = 1'b1;
   int       seq_cap = 400;
   logic [7:0] sensor_id = 8'd0;

   // tdata: restart, door_wait, option, load_ok, table_long, dose_level,
   // sensor_valid, read_id, turbidity, level_switch_set from bit 0 up
   function automatic logic [ReqDataW-1:0] pack_tick(item_type it);
      logic [ReqDataW-1:0] w;
      w        = '0;
      w[0]     = it.restart;
      w[1]     = it.door_wait;
      w[4:2]   = it.option;
      w[5]     = it.load_ok;
      w[6]     = it.table_long;
      w[10:7]  = it.dose_level;
      w[11]    = it.sensor_valid;
      w[19:12] = it.read_id;
      w[26:20] = it.turbidity;
      w[27]    = it.level_switch_set;
      return w;
   endfunction

   function automatic item_type unpack_tick(logic [ReqDataW-1:0] w);
      item_type it;
      it.restart          = w[0];
      it.door_wait        = w[1];
      it.option           = w[4:2];
      it.load_ok          = w[5];
      it.table_long       = w[6];
      it.dose_level       = w[10:7];
      it.sensor_valid     = w[11];
      it.read_id          = w[19:12];
      it.turbidity        = w[26:20];
      it.level_switch_set = w[27];
      return it;
   endfunction

   function automatic result_type unpack_outputs(logic [RspDataW-1:0] d);
      result_type r;
      r.done_res      = d[0];
      r.dispenser_on  = d[1];
      r.read_enable   = d[2];
      r.read_disable  = d[3];
      r.verdict_valid = d[4];
      r.aid_missing   = d[5];
      return r;
   endfunction

   function automatic void clear_sequencer();
      dosing_cfg.dose_time          = TimeReset;
      dosing_cfg.second_dose_time   = TimeReset;
      dosing_cfg.read_to_dose_delay = TimeReset;
      dosing_cfg.dose_gap_delay     = TimeReset;
      dosing_cfg.dose_to_read_delay = TimeReset;
      dosing_cfg.turbidity_delta    = DeltaReset;
      ph           = PH_INIT;
      countdown    = '0;
      counting     = 1'b0;
      seen_id      = '0;
      read_pending = 1'b0;
      dose_count   = '0;
      first_turb   = '0;
   endfunction

   // Advance the shadow sequencer by one tick and return its output word
   function automatic result_type step_sequencer(item_type it);
      result_type r;
      logic       run;
      int         rise;
      r   = '0;
      run = 1'b1;
      if (it.restart) begin
         ph  = PH_INIT;
         run = 1'b0;
      end else if (it.door_wait) begin
         // door open: timer frozen, an outstanding read gets re-requested
         counting = 1'b0;
         if (ph == PH_T1 || ph == PH_T2)
            read_pending = 1'b1;
         run = 1'b0;
      end else begin
         if (counting && countdown != 0)
            countdown = countdown - 1'b1;
         if (read_pending) begin
            seen_id       = it.read_id;
            read_pending  = 1'b0;
            r.read_enable = 1'b1;
         end
         case (ph)
            PH_INIT: begin
               if (!it.load_ok) begin
                  ph  = PH_ERROR;
                  run = 1'b0;
               end else if (it.dose_level == 0) begin
                  r.done_res = 1'b1;
                  run        = 1'b0;
               end else begin
                  countdown = '0;
                  if (it.option == OPT_PLAIN) begin
                     ph = PH_WAIT_D1;
                  end else if (it.option == OPT_TURB || it.option == OPT_REG_TURB) begin
                     if (!it.table_long) begin
                        ph  = PH_ERROR;
                        run = 1'b0;
                     end else begin
                        ph           = PH_T1;
                        read_pending = 1'b1;
                        dose_count   = '0;
                     end
                  end else if (it.option == OPT_REG) begin
                     ph         = PH_WAIT_D1;
                     dose_count = '0;
                  end else begin
                     ph = PH_ERROR;
                  end
               end
            end
            PH_T1: begin
               if (it.sensor_valid && seen_id != it.read_id) begin
                  seen_id        = it.read_id;
                  first_turb     = it.turbidity;
                  ph             = PH_WAIT_D1;
                  countdown      = dosing_cfg.read_to_dose_delay;
                  r.read_disable = 1'b1;
               end
            end
            PH_WAIT_D1: begin
               if (countdown == 0) begin
                  ph        = PH_D1;
                  countdown = dosing_cfg.dose_time;
               end
            end
            PH_D1: begin
               if (countdown == 0) begin
                  ph        = PH_WAIT_D2;
                  countdown = dosing_cfg.dose_gap_delay;
               end else begin
                  r.dispenser_on = 1'b1;
               end
            end
            PH_WAIT_D2: begin
               if (countdown == 0) begin
                  if (it.option == OPT_REG || it.option == OPT_REG_TURB) begin
                     // regulated: count doses, saturating
                     if (dose_count < DoseCountMax)
                        dose_count = dose_count + 1'b1;
                     if (dose_count >= it.dose_level) begin
                        ph = (it.option == OPT_REG_TURB) ? PH_WAIT_T2 : PH_END;
                     end else begin
                        ph        = PH_D1;
                        countdown = dosing_cfg.dose_time;
                     end
                  end else begin
                     ph        = PH_D2;
                     countdown = dosing_cfg.second_dose_time;
                  end
               end
            end
            PH_D2: begin
               if (countdown == 0) begin
                  if (it.option == OPT_PLAIN)
                     ph = PH_END;
                  else if (it.option == OPT_TURB)
                     ph = PH_WAIT_T2;
                  else
                     ph = PH_ERROR;
                  countdown = dosing_cfg.dose_to_read_delay;
               end else begin
                  r.dispenser_on = 1'b1;
               end
            end
            PH_WAIT_T2: begin
               if (countdown == 0) begin
                  ph           = PH_T2;
                  read_pending = 1'b1;
               end
            end
            PH_T2: begin
               if (it.sensor_valid && seen_id != it.read_id) begin
                  // a fall in turbidity counts as no rise
                  rise            = int'(it.turbidity) - int'(first_turb);
                  r.verdict_valid = 1'b1;
                  r.aid_missing   = !it.level_switch_set &&
                                    rise <= int'(dosing_cfg.turbidity_delta) &&
                                    (int'(first_turb) + int'(dosing_cfg.turbidity_delta))
                                       < int'(FullScale);
                  ph              = PH_END;
                  r.read_disable  = 1'b1;
               end
            end
            PH_END, PH_ERROR: r.done_res = 1'b1;
            default: ph = PH_INIT;
         endcase
         if (run)
            counting = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("mismatch %0d at %0t: %s", error_count, $time, msg);
   endtask

   task automatic compare_field(input string name, input logic want, input logic got);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s: expected %b, got %b",
                                   ticks_checked, name, want, got));
   endtask

   // Scoreboard: check output words, track register writes, predict accepted ticks
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         clear_sequencer();
         due_outputs.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_outputs(rsp_tdata);
            if (due_outputs.size() == 0) begin
               report_mismatch($sformatf("output word %b with nothing expected", rsp_tdata));
            end else begin
               want = due_outputs.pop_front();
               compare_field("done_res", want.done_res, got.done_res);
               compare_field("dispenser_on", want.dispenser_on, got.dispenser_on);
               compare_field("read_enable", want.read_enable, got.read_enable);
               compare_field("read_disable", want.read_disable, got.read_disable);
               compare_field("verdict_valid", want.verdict_valid, got.verdict_valid);
               compare_field("aid_missing", want.aid_missing, got.aid_missing);
            end
            ticks_checked++;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DOSE_TIME:    dosing_cfg.dose_time          = csr_wr_data;
               CSR_SECOND_DOSE:  dosing_cfg.second_dose_time   = csr_wr_data;
               CSR_READ_TO_DOSE: dosing_cfg.read_to_dose_delay = csr_wr_data;
               CSR_DOSE_GAP:     dosing_cfg.dose_gap_delay     = csr_wr_data;
               CSR_DOSE_TO_READ: dosing_cfg.dose_to_read_delay = csr_wr_data;
               CSR_TURB_DELTA:   dosing_cfg.turbidity_delta    = csr_wr_data[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = step_sequencer(unpack_tick(req_tdata));
            if (want.verdict_valid) verdict_count++;
            if (want.aid_missing) missing_count++;
            if (want.done_res) done_count++;
            if (want.dispenser_on) dispense_count++;
            due_outputs.push_back(want);
         end
      end
   end

   // Receiver: always ready, random stalls, or alternating ready/stall runs
   always @(negedge clock) begin
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (rx_run == 0) begin
               rx_hold = !rx_hold;
               rx_run  = rx_hold ? $urandom_range(1, 10) : $urandom_range(1, 6);
            end
            rx_run--;
            rsp_tready <= rx_hold;
         end
      endcase
   end

   // Send one tick word; called and returns at a falling edge
   task automatic send_word(input item_type it);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, tx_max_gap);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tdata  <= pack_tick(it);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      @(negedge clock);
   endtask

   // Hold off the sender until every expected word has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (due_outputs.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_times(input logic [15:0] dose, input logic [15:0] second,
                              input logic [15:0] to_dose, input logic [15:0] gap,
                              input logic [15:0] to_read, input logic [6:0] delta);
      settle();
      write_csr(CSR_DOSE_TIME, dose);
      write_csr(CSR_SECOND_DOSE, second);
      write_csr(CSR_READ_TO_DOSE, to_dose);
      write_csr(CSR_DOSE_GAP, gap);
      write_csr(CSR_DOSE_TO_READ, to_read);
      write_csr(CSR_TURB_DELTA, {9'd0, delta});
   endtask

   function automatic item_type mk(bit rs, bit dw, logic [2:0] op, bit ld, bit tl,
                                   logic [3:0] lv, bit sv, logic [7:0] id,
                                   logic [6:0] tu, bit ls);
      item_type it;
      it.restart          = rs;
      it.door_wait        = dw;
      it.option           = op;
      it.load_ok          = ld;
      it.table_long       = tl;
      it.dose_level       = lv;
      it.sensor_valid     = sv;
      it.read_id          = id;
      it.turbidity        = tu;
      it.level_switch_set = ls;
      return it;
   endfunction

   function automatic item_type random_tick();
      return mk($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 7),
                $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 15),
                $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 100),
                $urandom_range(0, 1));
   endfunction

   // Well-formed dosing runs with random content, mixed with noise ticks
   task automatic run_sequences(input int n_items, input int door_pct, input int noise_pct);
      int         sent;
      int         ticks;
      int         tail;
      int         r;
      logic [2:0] opt;
      logic [3:0] lvl;
      item_type   it;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_word(random_tick());
            sent++;
            continue;
         end
         r   = $urandom_range(0, 99);
         opt = (r < 6) ? $urandom_range(OPT_FIRST_BAD, OPT_LAST_BAD) : $urandom_range(0, 3);
         r   = $urandom_range(0, 99);
         lvl = (r < 5) ? 4'd0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(4, 15);
         it  = random_tick();
         it.restart = 1'b1;
         send_word(it);
         sent++;
         ticks = 0;
         tail  = $urandom_range(0, 3);
         while (sent < n_items && ticks < seq_cap) begin
            it = random_tick();
            it.restart      = ($urandom_range(0, 199) == 0);
            it.door_wait    = ($urandom_range(0, 99) < door_pct);
            it.option       = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 7) : opt;
            it.load_ok      = ($urandom_range(0, 19) != 0);
            it.table_long   = ($urandom_range(0, 19) != 0);
            it.dose_level   = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 15) : lvl;
            it.sensor_valid = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 2) == 0)
               sensor_id++;
            it.read_id = sensor_id;
            send_word(it);
            sent++;
            ticks++;
            if (!it.door_wait && (ph == PH_END || ph == PH_ERROR || ph == PH_INIT)) begin
               if (tail == 0)
                  break;
               tail--;
            end
         end
      end
   endtask

   // Error exits, zero level, door wait during a read, turbidity run to a verdict
   task automatic test_directed();
      tx_max_gap = 2;
      rx_mode    = 1;
      send_word(mk(1, 1, OPT_LAST_BAD, 1, 1, 15, 1, 255, 100, 1));
      send_word(mk(0, 0, OPT_PLAIN, 0, 0, 1, 0, 0, 0, 0));
      send_word(mk(0, 0, OPT_PLAIN, 1, 1, 1, 0, 0, 0, 0));
      send_word(mk(1, 0, OPT_PLAIN, 0, 0, 0, 0, 0, 0, 0));
      send_word(mk(0, 0, OPT_FIRST_BAD, 1, 1, 3, 0, 0, 0, 0));
      send_word(mk(1, 0, OPT_PLAIN, 1, 1, 1, 0, 0, 0, 0));
      send_word(mk(0, 0, OPT_REG, 1, 1, 0, 0, 0, 0, 0));
      send_word(mk(0, 0, OPT_REG_TURB, 1, 0, 2, 0, 0, 0, 0));
      write_times(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0);
      send_word(mk(1, 0, OPT_TURB, 1, 1, 1, 0, 0, 0, 0));
      send_word(mk(0, 0, OPT_TURB, 1, 1, 1, 0, 0, 0, 0));
      send_word(mk(0, 1, OPT_TURB, 1, 1, 1, 1, 8'd3, 50, 0));
      send_word(mk(0, 0, OPT_TURB, 1, 1, 1, 1, 8'd7, 100, 0));
      send_word(mk(0, 0, OPT_TURB, 1, 1, 1, 1, 8'd8, 100, 0));
      repeat (4) send_word(mk(0, 0, OPT_TURB, 1, 1, 1, 0, 8'd8, 0, 0));
      send_word(mk(0, 0, OPT_TURB, 1, 1, 1, 1, 8'd8, 0, 0));
      send_word(mk(0, 0, OPT_TURB, 1, 1, 1, 1, 8'd8, 0, 0));
      send_word(mk(0, 0, OPT_TURB, 1, 1, 1, 1, 8'd9, 0, 0));
      send_word(mk(0, 0, OPT_TURB, 1, 1, 1, 0, 8'd9, 0, 0));
      settle();
   endtask

   // Short phase times, no idling on either side
   task automatic test_short_times();
      write_times($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                  $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 100));
      tx_max_gap = 0;
      rx_mode    = 0;
      seq_cap    = 400;
      run_sequences(500, 4, 3);
   endtask

   task automatic test_zero_times();
      write_times(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0);
      tx_max_gap = 5;
      rx_mode    = 2;
      run_sequences(250, 6, 5);
   endtask

   task automatic test_reset_values();
      write_times(TimeReset, TimeReset, TimeReset, TimeReset, TimeReset, DeltaReset);
      tx_max_gap = 3;
      rx_mode    = 1;
      run_sequences(350, 3, 2);
   endtask

   // Longest phase times: runs are capped at seq_cap ticks before the next restart
   task automatic test_long_times();
      write_times(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd100);
      tx_max_gap = 4;
      rx_mode    = 2;
      seq_cap    = 40;
      run_sequences(200, 5, 5);
      seq_cap    = 400;
   endtask

   task automatic test_noise();
      write_times($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 8),
                  $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 100));
      tx_max_gap = 6;
      rx_mode    = 1;
      run_sequences(250, 10, 100);
   endtask

   // Several random settings with varied traffic
   task automatic test_mixed();
      for (int round = 0; round < 4; round++) begin
         write_times($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 12),
                     $urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 100));
         tx_max_gap = $urandom_range(0, 8);
         rx_mode    = round % 3;
         run_sequences(150, 8, 5);
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_short_times();
      test_zero_times();
      test_reset_values();
      test_long_times();
      test_noise();
      test_mixed();
      settle();
      repeat (6) @(negedge clock);
      $display("summary: %0d words checked, %0d done, %0d dispensing ticks",
               ticks_checked, done_count, dispense_count);
      $display("summary: %0d verdicts (%0d missing), %0d mismatches",
               verdict_count, missing_count, error_count);
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   // Run limit
   initial begin
      #2000000;
      $display("timeout with %0d words still expected", due_outputs.size());
      $display("tb: errors");
      $finish;
   end

endmodule

/* rinse_aid_dose_sequencer.f */
+incdir+src
src/rads_pkg.sv
src/rads_csr.sv
src/rads_step.sv
src/rinse_aid_dose_sequencer.sv
tb/tb.sv
